[src/ise_pkg.sv]
// Shared types and constants of the insertion sort engine.
package ise_pkg;

  localparam int unsigned VALUE_W = 32;

  typedef logic signed [VALUE_W-1:0] value_t;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_KEY_RD,
    ST_KEY_LD,
    ST_CMP_RD,
    ST_CMP,
    ST_OUT_RD,
    ST_OUT_LD,
    ST_OUT_WAIT
  } seq_state_t;

endpackage

[src/ise_ram.sv]
// Value store: one write port, one read port with registered read data.
module ise_ram #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned AW    = 6
) (
  input  logic            clk,
  input  logic            wr_en,
  input  logic [AW-1:0]   wr_addr,
  input  ise_pkg::value_t wr_data,
  input  logic [AW-1:0]   rd_addr,
  output ise_pkg::value_t rd_data
);

  ise_pkg::value_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

[src/ise_cmp.sv]
// Shared signed comparator: tells whether the stored value exceeds the key.
module ise_cmp (
  input  ise_pkg::value_t stored,
  input  ise_pkg::value_t key,
  output logic            greater
);

  assign greater = (stored > key);

endmodule

[src/insertion_sort_engine_core.sv]
// Top level of the insertion sort engine: load, sort and stream out one set of values.
//
// Values arrive one per accepted transaction into a single-port-write store of
// MAX_ITEMS entries; a transaction with in_item_last high closes the set.
// The engine then sorts the store in place, ascending and stable, using one comparator
// and the store's single read and write port: each key is read from the store, then
// compared with the values below it, every larger value is shifted up by one place,
// and the key is written where it settles.
// Results then leave one at a time (store read, output load, handshake).
// Input is not accepted from the closing transaction until the final result is taken.
// Values arriving with the store full are dropped and out_values_dropped is raised
// on every result of that set.
module insertion_sort_engine_core #(
  parameter int unsigned MAX_ITEMS = 64
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [ise_pkg::VALUE_W-1:0]  in_item_value,
  input  logic                                in_item_last,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [ise_pkg::VALUE_W-1:0]  out_sorted_value,
  output logic                                out_sorted_last,
  output logic                                out_values_dropped
);

  localparam int unsigned AW = $clog2(MAX_ITEMS);
  localparam int unsigned CW = $clog2(MAX_ITEMS + 1);
  localparam logic [CW-1:0] MAX_CNT = CW'(MAX_ITEMS);
  localparam logic [CW-1:0] ONE_CNT = CW'(1);

  ise_pkg::seq_state_t state_r, state_nxt;

  logic [CW-1:0]   count_r, count_nxt;
  logic            ovf_r, ovf_nxt;
  logic [CW-1:0]   outer_r, outer_nxt;
  logic [CW-1:0]   inner_r, inner_nxt;
  logic [CW-1:0]   k_r, k_nxt;
  ise_pkg::value_t key_r, key_nxt;

  logic            out_valid_r, out_valid_nxt;
  ise_pkg::value_t out_value_r, out_value_nxt;
  logic            out_last_r, out_last_nxt;
  logic            out_drop_r, out_drop_nxt;

  logic            wr_en;
  logic [CW-1:0]   wr_idx;
  ise_pkg::value_t wr_data;
  logic [CW-1:0]   rd_idx;
  ise_pkg::value_t rd_data;
  logic            greater;
  logic            in_fire;
  logic [CW-1:0]   inner_dec;

  assign in_fire   = in_valid && in_ready;
  assign inner_dec = inner_r - ONE_CNT;

  ise_ram #(
    .DEPTH (MAX_ITEMS),
    .AW    (AW)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_idx[AW-1:0]),
    .wr_data (wr_data),
    .rd_addr (rd_idx[AW-1:0]),
    .rd_data (rd_data)
  );

  ise_cmp u_cmp (
    .stored  (rd_data),
    .key     (key_r),
    .greater (greater)
  );

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ise_pkg::ST_LOAD: begin
        if (in_fire && in_item_last) state_nxt = ise_pkg::ST_KEY_RD;
      end
      ise_pkg::ST_KEY_RD: begin
        if (outer_r >= count_r) state_nxt = ise_pkg::ST_OUT_RD;
        else                    state_nxt = ise_pkg::ST_KEY_LD;
      end
      ise_pkg::ST_KEY_LD: state_nxt = ise_pkg::ST_CMP_RD;
      ise_pkg::ST_CMP_RD: begin
        if (inner_r == '0) state_nxt = ise_pkg::ST_KEY_RD;
        else               state_nxt = ise_pkg::ST_CMP;
      end
      ise_pkg::ST_CMP: begin
        if (greater) state_nxt = ise_pkg::ST_CMP_RD;
        else         state_nxt = ise_pkg::ST_KEY_RD;
      end
      ise_pkg::ST_OUT_RD: state_nxt = ise_pkg::ST_OUT_LD;
      ise_pkg::ST_OUT_LD: state_nxt = ise_pkg::ST_OUT_WAIT;
      ise_pkg::ST_OUT_WAIT: begin
        if (out_ready) begin
          if (out_last_r) state_nxt = ise_pkg::ST_LOAD;
          else            state_nxt = ise_pkg::ST_OUT_RD;
        end
      end
      default: state_nxt = ise_pkg::ST_LOAD;
    endcase
  end

  always_comb begin
    in_ready      = 1'b0;
    wr_en         = 1'b0;
    wr_idx        = count_r;
    wr_data       = in_item_value;
    rd_idx        = outer_r;
    count_nxt     = count_r;
    ovf_nxt       = ovf_r;
    outer_nxt     = outer_r;
    inner_nxt     = inner_r;
    k_nxt         = k_r;
    key_nxt       = key_r;
    out_valid_nxt = out_valid_r;
    out_value_nxt = out_value_r;
    out_last_nxt  = out_last_r;
    out_drop_nxt  = out_drop_r;
    unique case (state_r)
      ise_pkg::ST_LOAD: begin
        in_ready = 1'b1;
        if (in_fire) begin
          if (count_r < MAX_CNT) begin
            wr_en     = 1'b1;
            count_nxt = count_r + ONE_CNT;
          end else begin
            ovf_nxt = 1'b1;
          end
          if (in_item_last) outer_nxt = ONE_CNT;
        end
      end
      ise_pkg::ST_KEY_RD: begin
        rd_idx    = outer_r;
        inner_nxt = outer_r;
        k_nxt     = '0;
      end
      ise_pkg::ST_KEY_LD: begin
        key_nxt = rd_data;
      end
      ise_pkg::ST_CMP_RD: begin
        rd_idx = inner_dec;
        if (inner_r == '0) begin
          wr_en     = 1'b1;
          wr_idx    = '0;
          wr_data   = key_r;
          outer_nxt = outer_r + ONE_CNT;
        end
      end
      ise_pkg::ST_CMP: begin
        wr_en  = 1'b1;
        wr_idx = inner_r;
        if (greater) begin
          wr_data   = rd_data;
          inner_nxt = inner_dec;
        end else begin
          wr_data   = key_r;
          outer_nxt = outer_r + ONE_CNT;
        end
      end
      ise_pkg::ST_OUT_RD: begin
        rd_idx = k_r;
      end
      ise_pkg::ST_OUT_LD: begin
        out_valid_nxt = 1'b1;
        out_value_nxt = rd_data;
        out_last_nxt  = ((k_r + ONE_CNT) == count_r);
        out_drop_nxt  = ovf_r;
      end
      ise_pkg::ST_OUT_WAIT: begin
        if (out_ready) begin
          out_valid_nxt = 1'b0;
          k_nxt         = k_r + ONE_CNT;
          if (out_last_r) begin
            count_nxt = '0;
            ovf_nxt   = 1'b0;
          end
        end
      end
      default: begin
        out_valid_nxt = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ise_pkg::ST_LOAD;
      count_r     <= '0;
      ovf_r       <= 1'b0;
      outer_r     <= '0;
      inner_r     <= '0;
      k_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      ovf_r       <= ovf_nxt;
      outer_r     <= outer_nxt;
      inner_r     <= inner_nxt;
      k_r         <= k_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    key_r       <= key_nxt;
    out_value_r <= out_value_nxt;
    out_last_r  <= out_last_nxt;
    out_drop_r  <= out_drop_nxt;
  end

  assign out_valid          = out_valid_r;
  assign out_sorted_value   = out_value_r;
  assign out_sorted_last    = out_last_r;
  assign out_values_dropped = out_drop_r;

endmodule
